FILE: hdl/rme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rme_pkg;

  localparam int TabLen = 24;
  localparam int AngW = 28;     // angle width, units of 2^-24 rad
  localparam int VecW = 30;     // CORDIC vector width (x may grow by ~1.65)
  localparam int SqW = 46;      // radicand width for the square root
  localparam int RootW = 23;    // square root result width

  localparam logic signed [AngW-1:0] PiQ24 = 28'sd52707179;
  localparam logic signed [16:0] HalfPiQ13 = 17'sd12868;
  localparam logic signed [16:0] PiQ13 = 17'sd25736;
  localparam logic signed [16:0] YMaxQ13 = 17'sd38604;
  localparam logic signed [15:0] OneQ14 = 16'sd16384;

  typedef enum logic [1:0] {
    CASE_FIRST  = 2'd0,
    CASE_SECOND = 2'd1,
    CASE_LOCK_N = 2'd2,
    CASE_LOCK_P = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] z;
  } cvec_t;

  // Side data that travels with one item along the chain.
  typedef struct packed {
    logic signed [15:0] rz;
    case_t              kind;
  } side_t;

  function automatic logic signed [AngW-1:0] atan_tab(input int i);
    logic signed [AngW-1:0] t;
    case (i)
      0: t = 28'sd13176795;
      1: t = 28'sd7778716;
      2: t = 28'sd4110060;
      3: t = 28'sd2086331;
      4: t = 28'sd1047214;
      5: t = 28'sd524117;
      6: t = 28'sd262123;
      7: t = 28'sd131069;
      default: t = (i < TabLen) ? (AngW'(1) <<< (24 - i)) : '0;
    endcase
    return t;
  endfunction

  // Round a 2^-24 angle to Q3.13 and saturate.
  function automatic logic signed [16:0] to_q13(input logic signed [AngW-1:0] v,
                                                input logic signed [16:0] lo,
                                                input logic signed [16:0] hi);
    logic signed [AngW:0] s;
    logic signed [AngW-11:0] r;
    logic signed [16:0] o;
    s = {v[AngW-1], v} + (AngW+1)'(1024);
    r = s[AngW:11];
    if (r < (AngW-10)'(lo)) o = lo;
    else if (r > (AngW-10)'(hi)) o = hi;
    else o = r[16:0];
    return o;
  endfunction

  function automatic logic [16:0] abs17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/rme_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rme_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_z;
  logic signed [15:0] front_x;
  logic signed [15:0] front_z;
  modport source (output valid, right_x, right_y, right_z, up_x, up_z, front_x, front_z,
                  input ready);
  modport sink (input valid, right_x, right_y, right_z, up_x, up_z, front_x, front_z,
                output ready);
endinterface

interface rme_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] angle_x;
  logic signed [16:0] angle_y;
  logic signed [15:0] angle_z;
  logic [1:0] case_taken;
  modport source (output valid, angle_x, angle_y, angle_z, case_taken, input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, case_taken, output ready);
endinterface
`default_nettype wire

FILE: hdl/rotation_matrix_to_euler_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Rotation matrix to Euler angle converter.
// Input channel (in): seven Q1.14 matrix elements per beat. Output channel (out):
// angles x, y, z in Q3.13 radians and the two-bit case code, one beat per input.
// The datapath is a chain of cells: 23 square root cells produce cos(pitch),
// then CORDIC_STAGES atan2 cells run five angles in parallel, then one rounding
// stage and the output register, which also selects the solution. One beat is
// accepted every cycle while the output is not stalled.
// The whole chain advances only when the output register is free or being read,
// so a receiver stall holds every stage in place and in_ready drops with it.
// Reset (rst_n low, synchronous) clears the valid bits of all stages; no item
// is in flight afterward. Payload registers are not reset.
module rotation_matrix_to_euler_core #(
  parameter int CORDIC_STAGES = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  rme_in_if.sink   in_ch,
  rme_out_if.source out_ch
);
  import rme_pkg::*;
  localparam int SqN = RootW;
  localparam int Depth = SqN + CORDIC_STAGES + 1;

  logic en;
  logic vld_r [Depth+1];
  logic out_vld_r;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;
  assign out_ch.valid = out_vld_r;

  // Valid and side-data chain.
  logic [15:0] ux_d [SqN+1], fx_d [SqN+1], uz_d [SqN+1], fz_d [SqN+1];
  logic [15:0] rx_d [SqN+1], ry_d [SqN+1];
  side_t sd [Depth+1];
  side_t sd_in;

  always_comb begin
    sd_in.rz = in_ch.right_z;
    if (in_ch.right_z == -OneQ14) sd_in.kind = CASE_LOCK_N;
    else if (in_ch.right_z == OneQ14) sd_in.kind = CASE_LOCK_P;
    else sd_in.kind = CASE_FIRST;
  end

  assign vld_r[0] = in_ch.valid;
  assign sd[0] = sd_in;
  assign ux_d[0] = in_ch.up_x;
  assign fx_d[0] = in_ch.front_x;
  assign uz_d[0] = in_ch.up_z;
  assign fz_d[0] = in_ch.front_z;
  assign rx_d[0] = in_ch.right_x;
  assign ry_d[0] = in_ch.right_y;

  for (genvar g = 0; g < Depth; g++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else if (en) vld_r[g+1] <= vld_r[g];
    end
    always_ff @(posedge clk) begin
      if (en) sd[g+1] <= sd[g];
    end
  end

  for (genvar g = 0; g < SqN; g++) begin : g_pay
    always_ff @(posedge clk) begin
      if (en) begin
        ux_d[g+1] <= ux_d[g];
        fx_d[g+1] <= fx_d[g];
        uz_d[g+1] <= uz_d[g];
        fz_d[g+1] <= fz_d[g];
        rx_d[g+1] <= rx_d[g];
        ry_d[g+1] <= ry_d[g];
      end
    end
  end

  // cos(pitch) = sqrt((2^28 - s^2) * 2^16), s clamped to one.
  logic signed [15:0] s_cl;
  logic [SqW-1:0] rad;
  logic [29:0] s_sq;
  logic [SqW-1:0] rem [SqN+1];
  logic [RootW-1:0] root [SqN+1];

  always_comb begin
    if (in_ch.right_z > OneQ14) s_cl = OneQ14;
    else if (in_ch.right_z < -OneQ14) s_cl = -OneQ14;
    else s_cl = in_ch.right_z;
    s_sq = 30'(32'(s_cl) * 32'(s_cl));
    rad = SqW'(30'(1 << 28) - s_sq) << 16;
  end
  assign rem[0] = rad;
  assign root[0] = '0;

  for (genvar g = 0; g < SqN; g++) begin : g_sq
    rme_sqrt_cell #(.Step(g)) u_sq (
      .clk(clk), .en(en), .rem_in(rem[g]), .root_in(root[g]),
      .rem_r(rem[g+1]), .root_r(root[g+1])
    );
  end

  // Five atan2 chains; the second solution's x and z use negated arguments,
  // as does the lock at +1.
  logic signed [15:0] s2;
  logic signed [VecW-1:0] py, px, xy, xx, x2y, x2x, zy, zx, z2y, z2x;
  logic signed [AngW-1:0] a_p, a_x1, a_x2, a_z1, a_z2;
  logic signed [VecW-1:0] lux, lfx;
  logic lock_p, lock;

  always_comb begin
    s2 = sd[SqN].rz;
    if (s2 > OneQ14) s2 = OneQ14;
    else if (s2 < -OneQ14) s2 = -OneQ14;
    lock = sd[SqN].kind != CASE_FIRST;
    lock_p = sd[SqN].kind == CASE_LOCK_P;
    lux = VecW'($signed(ux_d[SqN])) <<< 8;
    lfx = VecW'($signed(fx_d[SqN])) <<< 8;
    py = VecW'(s2) <<< 8;
    px = VecW'(root[SqN]);
    xy = VecW'($signed(uz_d[SqN])) <<< 8;
    xx = VecW'($signed(fz_d[SqN])) <<< 8;
    x2y = -xy;
    x2x = -xx;
    zy = lock ? (lock_p ? -lux : lux) : VecW'($signed(ry_d[SqN])) <<< 8;
    zx = lock ? (lock_p ? -lfx : lfx) : VecW'($signed(rx_d[SqN])) <<< 8;
    z2y = VecW'(-($signed(ry_d[SqN]) * 256));
    z2x = VecW'(-($signed(rx_d[SqN]) * 256));
  end

  rme_cordic_chain #(.Stages(CORDIC_STAGES)) u_p (
    .clk(clk), .en(en), .y_in(py), .x_in(px), .ang(a_p));
  rme_cordic_chain #(.Stages(CORDIC_STAGES)) u_x1 (
    .clk(clk), .en(en), .y_in(xy), .x_in(xx), .ang(a_x1));
  rme_cordic_chain #(.Stages(CORDIC_STAGES)) u_x2 (
    .clk(clk), .en(en), .y_in(x2y), .x_in(x2x), .ang(a_x2));
  rme_cordic_chain #(.Stages(CORDIC_STAGES)) u_z1 (
    .clk(clk), .en(en), .y_in(zy), .x_in(zx), .ang(a_z1));
  rme_cordic_chain #(.Stages(CORDIC_STAGES)) u_z2 (
    .clk(clk), .en(en), .y_in(z2y), .x_in(z2x), .ang(a_z2));

  // Rounding stage.
  localparam int Cs = SqN + CORDIC_STAGES;
  logic signed [16:0] x1q_r, x2q_r, y1q_r, y2q_r, z1q_r, z2q_r;
  logic signed [AngW-1:0] y1, y2;
  assign y1 = -a_p;
  assign y2 = PiQ24 - y1;

  always_ff @(posedge clk) begin
    if (en) begin
      x1q_r <= to_q13(a_x1, -PiQ13, PiQ13);
      x2q_r <= to_q13(a_x2, -PiQ13, PiQ13);
      z1q_r <= to_q13(a_z1, -PiQ13, PiQ13);
      z2q_r <= to_q13(a_z2, -PiQ13, PiQ13);
      y1q_r <= to_q13(y1, -HalfPiQ13, YMaxQ13);
      y2q_r <= to_q13(y2, -HalfPiQ13, YMaxQ13);
    end
  end

  // Select and output register.
  logic [18:0] sum1, sum2;
  logic signed [15:0] ax_r, az_r;
  logic signed [16:0] ay_r;
  case_t ct_r;
  case_t k;
  assign k = sd[Depth].kind;
  assign sum1 = 19'(abs17(x1q_r)) + 19'(abs17(y1q_r)) + 19'(abs17(z1q_r));
  assign sum2 = 19'(abs17(x2q_r)) + 19'(abs17(y2q_r)) + 19'(abs17(z2q_r));

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= vld_r[Depth];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      az_r <= z1q_r[15:0];
      case (k)
        CASE_LOCK_N: begin
          ax_r <= '0; ay_r <= HalfPiQ13; ct_r <= CASE_LOCK_N;
        end
        CASE_LOCK_P: begin
          ax_r <= '0; ay_r <= -HalfPiQ13; ct_r <= CASE_LOCK_P;
        end
        default: begin
          if (sum1 <= sum2) begin
            ax_r <= x1q_r[15:0]; ay_r <= y1q_r; ct_r <= CASE_FIRST;
          end else begin
            ax_r <= x2q_r[15:0]; ay_r <= y2q_r; az_r <= z2q_r[15:0];
            ct_r <= CASE_SECOND;
          end
        end
      endcase
    end
  end

  assign out_ch.angle_x = ax_r;
  assign out_ch.angle_y = ay_r;
  assign out_ch.angle_z = az_r;
  assign out_ch.case_taken = ct_r;

  logic unused;
  assign unused = ^{rem[SqN], vld_r[Cs]};

`ifndef ASSERT_OFF
  a_lock_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (ct_r == CASE_LOCK_N || ct_r == CASE_LOCK_P) |-> ax_r == '0)
    else $error("lock case with nonzero angle_x");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_ch.ready |=> out_vld_r && $stable(ay_r) && $stable(ct_r))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ay_r >= -HalfPiQ13 && ay_r <= YMaxQ13)
    else $error("angle_y out of range");
`endif
endmodule
`default_nettype wire

FILE: hdl/rme_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One restoring step of the integer square root: one result bit per cell.
module rme_sqrt_cell #(
  parameter int Step = 0
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [rme_pkg::SqW-1:0]   rem_in,
  input  wire logic [rme_pkg::RootW-1:0] root_in,
  output logic [rme_pkg::SqW-1:0]        rem_r,
  output logic [rme_pkg::RootW-1:0]      root_r
);
  import rme_pkg::*;
  localparam int Sh = 2 * (RootW - 1 - Step);

  logic [SqW+1:0] trial;
  logic [SqW-1:0] rem_nxt;
  logic [RootW-1:0] root_nxt;

  always_comb begin
    // Trial subtrahend (4*root + 1) << Sh, with root holding the upper bits.
    trial = ({2'b0, (SqW)'({root_in, 2'b01})}) << Sh;
    if ({2'b0, rem_in} >= trial) begin
      rem_nxt = rem_in - trial[SqW-1:0];
      root_nxt = {root_in[RootW-2:0], 1'b1};
    end else begin
      rem_nxt = rem_in;
      root_nxt = {root_in[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      root_r <= root_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/rme_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// One vectoring CORDIC micro-rotation.
module rme_cordic_cell #(
  parameter int Stage = 0
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  rme_pkg::cvec_t      v_in,
  output rme_pkg::cvec_t      v_r
);
  import rme_pkg::*;
  cvec_t v_nxt;
  logic signed [VecW-1:0] dx, dy;
  logic signed [AngW-1:0] a;

  always_comb begin
    dx = v_in.y >>> Stage;
    dy = v_in.x >>> Stage;
    a = atan_tab(Stage);
    if (!v_in.y[VecW-1]) begin
      v_nxt.x = v_in.x + dx;
      v_nxt.y = v_in.y - dy;
      v_nxt.z = v_in.z + a;
    end else begin
      v_nxt.x = v_in.x - dx;
      v_nxt.y = v_in.y + dy;
      v_nxt.z = v_in.z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) v_r <= v_nxt;
  end
endmodule
`default_nettype wire

FILE: hdl/rme_cordic_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// atan2(y, x): quadrant fold, then Stages micro-rotation cells.
module rme_cordic_chain #(
  parameter int Stages = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [rme_pkg::VecW-1:0] y_in,
  input  wire logic signed [rme_pkg::VecW-1:0] x_in,
  output logic signed [rme_pkg::AngW-1:0]      ang
);
  import rme_pkg::*;
  cvec_t v [Stages+1];
  logic zero;

  always_comb begin
    v[0].x = x_in;
    v[0].y = y_in;
    v[0].z = '0;
    if (x_in[VecW-1]) begin
      v[0].x = -x_in;
      v[0].y = -y_in;
      v[0].z = y_in[VecW-1] ? -PiQ24 : PiQ24;
    end
  end
  assign zero = (x_in == '0) && (y_in == '0);

  // Zero flag rides alongside the cells.
  logic zero_d [Stages+1];
  assign zero_d[0] = zero;
  for (genvar g = 0; g < Stages; g++) begin : g_cell
    rme_cordic_cell #(.Stage(g)) u_cell (
      .clk(clk), .en(en), .v_in(v[g]), .v_r(v[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) zero_d[g+1] <= zero_d[g];
    end
  end

  assign ang = zero_d[Stages] ? '0 : v[Stages].z;
endmodule
`default_nettype wire

FILE: tb/rme_tb_if.sv
`timescale 1ns / 1ps
// The block's channel interfaces live in hdl/rme_if.sv; this file only gathers
// the testbench-side channel types so the bench compiles in a fixed order.
package rme_tb_types;
  typedef struct {
    logic signed [15:0] rx, ry, rz, ux, uz, fx, fz;
  } matrix_t;
  typedef struct {
    logic signed [15:0] ax;
    logic signed [16:0] ay;
    logic signed [15:0] az;
    logic [1:0] kind;
  } euler_t;
endpackage

FILE: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import rme_pkg::*;
  import rme_tb_types::*;

  localparam int Stages = 16;
  localparam longint PiFix = 52707179;
  localparam longint LimitCycles = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  rme_in_if in_ch();
  rme_out_if out_ch();

  rotation_matrix_to_euler_core #(.CORDIC_STAGES(Stages)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  matrix_t pending[$];
  euler_t expected[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int n_lock = 0;
  int n_second = 0;
  int n_beats = 0;
  longint cycles = 0;
  int send_idle_pct_tab[4] = '{0, 69, 0, 22};
  int recv_stall_pct_tab[4] = '{0, 0, 69, 22};

  localparam longint AtanFix[24] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2};

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint a, dx, dy;
    a = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      a = (y >= 0) ? PiFix : -PiFix;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages && i < 24; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; a += AtanFix[i];
      end else begin
        x -= dx; y += dy; a -= AtanFix[i];
      end
    end
    return a;
  endfunction

  function automatic longint round_q13(longint v, longint lo, longint hi);
    longint r;
    r = floor_shift(v + 1024, 11);
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic euler_t decompose(matrix_t m);
    euler_t e;
    longint s, c, p1, p2, x1, x2, y1, y2, z1, z2;
    if (m.rz == -16384) begin
      e.ax = 0;
      e.ay = 12868;
      e.az = 16'(round_q13(vector_angle(m.ux * 256, m.fx * 256), -25736, 25736));
      e.kind = CASE_LOCK_N;
    end else if (m.rz == 16384) begin
      e.ax = 0;
      e.ay = -12868;
      e.az = 16'(round_q13(vector_angle(-m.ux * 256, -m.fx * 256), -25736, 25736));
      e.kind = CASE_LOCK_P;
    end else begin
      s = m.rz;
      if (s > 16384) s = 16384;
      if (s < -16384) s = -16384;
      c = int_sqrt((64'sd268435456 - s * s) * 65536);
      p1 = -vector_angle(s * 256, c);
      p2 = PiFix - p1;
      x1 = round_q13(vector_angle(m.uz * 256, m.fz * 256), -25736, 25736);
      x2 = round_q13(vector_angle(-m.uz * 256, -m.fz * 256), -25736, 25736);
      z1 = round_q13(vector_angle(m.ry * 256, m.rx * 256), -25736, 25736);
      z2 = round_q13(vector_angle(-m.ry * 256, -m.rx * 256), -25736, 25736);
      y1 = round_q13(p1, -12868, 38604);
      y2 = round_q13(p2, -12868, 38604);
      if (absl(x1) + absl(y1) + absl(z1) <= absl(x2) + absl(y2) + absl(z2)) begin
        e.ax = 16'(x1); e.ay = 17'(y1); e.az = 16'(z1); e.kind = CASE_FIRST;
      end else begin
        e.ax = 16'(x2); e.ay = 17'(y2); e.az = 16'(z2); e.kind = CASE_SECOND;
      end
    end
    return e;
  endfunction

  function automatic logic signed [15:0] any_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom_range(0, 65535));
    if (r == 1) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    if (r == 2) return 16'($signed($urandom_range(0, 6)) - 3);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic queue_matrix(int a, int b, int c, int d, int e, int f, int g);
    matrix_t m;
    m.rx = 16'(a); m.ry = 16'(b); m.rz = 16'(c); m.ux = 16'(d);
    m.uz = 16'(e); m.fx = 16'(f); m.fz = 16'(g);
    pending.push_back(m);
  endtask

  task automatic queue_random(int n);
    matrix_t m;
    for (int i = 0; i < n; i++) begin
      m.rx = any_elem(); m.ry = any_elem(); m.uz = any_elem(); m.fz = any_elem();
      m.ux = any_elem(); m.fx = any_elem();
      case ($urandom_range(0, 9))
        0: m.rz = -16'sd16384;
        1: m.rz = 16'sd16384;
        2: m.rz = ($urandom_range(0, 1) != 0) ? 16'sd16383 : -16'sd16383;
        default: m.rz = any_elem();
      endcase
      pending.push_back(m);
    end
  endtask

  // Driver: a new beat is loaded only when the current one is gone.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected.push_back(decompose('{in_ch.right_x, in_ch.right_y,
          in_ch.right_z, in_ch.up_x, in_ch.up_z, in_ch.front_x, in_ch.front_z}));
      if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        matrix_t m;
        m = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.right_x <= m.rx; in_ch.right_y <= m.ry; in_ch.right_z <= m.rz;
        in_ch.up_x <= m.ux; in_ch.up_z <= m.uz;
        in_ch.front_x <= m.fx; in_ch.front_z <= m.fz;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: compares every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        euler_t e;
        n_beats++;
        if (expected.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          e = expected.pop_front();
          if (e.kind >= CASE_LOCK_N) n_lock++;
          if (e.kind == CASE_SECOND) n_second++;
          if (out_ch.angle_x !== e.ax) begin
            $error("angle_x expected %0d got %0d", e.ax, out_ch.angle_x); errors++;
          end
          if (out_ch.angle_y !== e.ay) begin
            $error("angle_y expected %0d got %0d", e.ay, out_ch.angle_y); errors++;
          end
          if (out_ch.angle_z !== e.az) begin
            $error("angle_z expected %0d got %0d", e.az, out_ch.angle_z); errors++;
          end
          if (out_ch.case_taken !== e.kind) begin
            $error("case_taken expected %0d got %0d", e.kind, out_ch.case_taken);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LimitCycles) begin
      $display("timeout with %0d results outstanding", expected.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.right_x = 0; in_ch.right_y = 0; in_ch.right_z = 0;
    in_ch.up_x = 0; in_ch.up_z = 0; in_ch.front_x = 0; in_ch.front_z = 0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: identity, both lock cases, zero vectors, extremes, near-lock.
    queue_matrix(16384, 0, 0, 0, 16384, 0, 16384);
    queue_matrix(0, 0, -16384, 0, 0, 0, 0);
    queue_matrix(0, 0, 16384, 0, 0, 0, 0);
    queue_matrix(0, 0, -16384, 16384, 0, -16384, 0);
    queue_matrix(0, 0, 16384, -16384, 0, 16384, 0);
    queue_matrix(0, 0, -16384, 0, 0, -16384, 0);
    queue_matrix(0, 0, 16384, 0, 0, 16384, 0);
    queue_matrix(0, 0, 0, 0, 0, 0, 0);
    queue_matrix(-16384, 0, 0, 0, 0, 0, -16384);
    queue_matrix(-16384, -1, 16383, 0, 1, 0, -16384);
    queue_matrix(16384, 16384, -16383, 16384, -16384, 16384, -16384);
    queue_matrix(-32768, 32767, 32767, -32768, 32767, -32768, 32767);
    queue_matrix(32767, -32768, -32768, 32767, -32768, 32767, -32768);
    queue_matrix(0, 16384, 8192, 0, -16384, 0, 0);
    queue_matrix(-1, 0, -8192, 0, 0, -1, -16384);
    queue_matrix(0, -16384, 1, 3, -1, -3, 1);

    foreach (send_idle_pct_tab[p]) begin
      send_idle_pct = send_idle_pct_tab[p];
      recv_stall_pct = recv_stall_pct_tab[p];
      queue_random(p == 0 ? 145 : 165);
      while (pending.size() > 0 || in_ch.valid) @(posedge clk);
    end
    while (expected.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("%0d results checked, %0d in gimbal lock, %0d on the second solution",
             n_beats, n_lock, n_second);
    $display("stall phases: none, sender idle, receiver stalls, both");
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
